// ===== rtl/core/tmtw_pkg.sv =====
// Shared types and constants for the text-mode terminal writer core.
// Used by the core, the cursor step logic and the port checker.
// No dependencies.
package tmtw_pkg;

	// Field widths on the stream ports
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int POS_W     = 11;
	localparam int CELL_W    = 16;
	localparam int ATTR_W    = 8;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Tab stops sit on multiples of this power of two
	localparam int TAB_STOP = 8;

	// Character codes with special handling
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	// Attribute after reset and the cell value the screen powers up with
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Memory and sequencing controls from one put step
	typedef struct packed {
		logic wr_en;    // write a cell
		logic wr_blank; // write a blank instead of the character
		logic wr_back;  // target the cell before the cursor
		logic scroll;   // cursor hit the last row, scroll the screen
	} put_ctl_t;

endpackage

// ===== rtl/core/tmtw_cursor.sv =====
// Cursor update for one put: newline, backspace, tab and plain characters.
// Depends on tmtw_pkg.
module tmtw_cursor #(
	parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
	input  logic [$clog2(ROWS)-1:0]         row_q,
	input  logic [$clog2(COLUMNS)-1:0]      col_q,
	input  logic [tmtw_pkg::CHAR_W-1:0]     char_code,
	output logic [$clog2(ROWS)-1:0]         row_d,
	output logic [$clog2(COLUMNS)-1:0]      col_d,
	output tmtw_pkg::put_ctl_t              ctl
);
	import tmtw_pkg::*;

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	logic [CW:0] col_inc;
	logic [CW:0] tab_col;

	// Next column candidates, one bit wider to see the wrap
	assign col_inc = {1'b0, col_q} + (CW+1)'(1);
	assign tab_col = {1'b0, col_q & ~CW'(TAB_STOP - 1)} + (CW+1)'(TAB_STOP);

	always_comb begin
		row_d = row_q;
		col_d = col_q;
		ctl   = '0;
		case (char_code)
			CH_NEWLINE: begin
				col_d = '0;
				row_d = row_q + RW'(1);
			end
			CH_BACKSPACE: begin
				// at the origin do nothing
				if (row_q != '0 || col_q != '0) begin
					ctl.wr_en    = 1'b1;
					ctl.wr_blank = 1'b1;
					ctl.wr_back  = 1'b1;
					if (col_q == '0) begin
						col_d = CW'(COLUMNS - 1);
						row_d = row_q - RW'(1);
					end else begin
						col_d = col_q - CW'(1);
					end
				end
			end
			CH_TAB: begin
				if (tab_col >= (CW+1)'(COLUMNS)) begin
					col_d = '0;
					row_d = row_q + RW'(1);
				end else begin
					col_d = tab_col[CW-1:0];
				end
			end
			default: begin
				ctl.wr_en = 1'b1;
				if (col_inc >= (CW+1)'(COLUMNS)) begin
					col_d = '0;
					row_d = row_q + RW'(1);
				end else begin
					col_d = col_inc[CW-1:0];
				end
			end
		endcase
		// Pull the cursor back up one row when it lands on the last row
		if (row_d == RW'(ROWS - 1)) begin
			ctl.scroll = 1'b1;
			row_d      = RW'(ROWS - 2);
		end
	end

endmodule

// ===== rtl/core/text_mode_terminal_writer_core.sv =====
// Text-mode terminal writer: screen memory of ROWS x COLUMNS cells and a cursor.
// Put without scroll and unused op register their result at acceptance, a read passes
// through ST_READ first, clear and scroll make one copy/blank pass over (ROWS-1)*COLUMNS cells.
// Throughput: one item per cycle for puts that do not scroll, while the result register is free.
// Reset: cursor to origin, attribute 0x0F, then a clearing pass over all ROWS*COLUMNS
// cells fills the screen with blanks while s_tready stays low.
module text_mode_terminal_writer_core #(
	parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmtw_pkg::ATTR_W-1:0]      cfg_wdata,    // color_attribute
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tmtw_pkg::S_TDATA_W-1:0]   s_tdata,      // char_code, cell_index
	input  logic [tmtw_pkg::OP_W-1:0]        s_tuser,      // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tmtw_pkg::M_TDATA_W-1:0]   m_tdata       // cursor_position, cell_data
);
	import tmtw_pkg::*;

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int AW         = $clog2(CELLS);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int WORK_CELLS = (ROWS - 1) * COLUMNS;
	localparam int COPY_CELLS = (ROWS - 2) * COLUMNS;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SWEEP, ST_DRAIN} state_t;
	typedef enum logic [1:0] {SW_INIT, SW_CLEAR, SW_SCROLL} sweep_t;

	state_t               state_q;
	sweep_t               mode_q;
	logic [AW-1:0]        sweep_q;
	logic [AW-1:0]        last_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic [ATTR_W-1:0]    attr_q;
	logic                 m_tvalid_q;
	logic [POS_W-1:0]     pos_q;
	logic [CELL_W-1:0]    data_q;
	logic                 rd_ok_q;
	logic                 wr_s1;
	logic [AW-1:0]        wa_s1;
	logic                 cp_s1;

	logic [CELL_W-1:0]    mem [CELLS];
	logic [CELL_W-1:0]    rd_q;

	op_t                  op;
	logic [CHAR_W-1:0]    char_code;
	logic [INDEX_W-1:0]   cell_index;
	logic                 accept;
	logic                 out_free;
	logic                 index_ok;
	logic [RW-1:0]        row_d;
	logic [CW-1:0]        col_d;
	put_ctl_t             ctl;
	logic [AW-1:0]        cur_addr;
	logic [AW-1:0]        step_addr;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [CELL_W-1:0]    mem_wd;
	logic [AW-1:0]        mem_ra;

	// Unpack the input word
	assign op         = op_t'(s_tuser);
	assign char_code  = s_tdata[CHAR_W-1:0];
	assign cell_index = s_tdata[CHAR_W +: INDEX_W];

	// Take a word only when idle and the result register is free or draining
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign index_ok = 32'(cell_index) < 32'(CELLS);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - POS_W - CELL_W)'(0), data_q, pos_q};

	tmtw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.row_q     (row_q),
		.col_q     (col_q),
		.char_code (char_code),
		.row_d     (row_d),
		.col_d     (col_d),
		.ctl       (ctl)
	);

	// Linear cell addresses of the current and the stepped cursor
	assign cur_addr  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign step_addr = AW'(row_d) * AW'(COLUMNS) + AW'(col_d);

	// Steer the memory ports between the sweep pipeline and single accesses
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_s1;
		mem_wd = {attr_q, BLANK_CHAR};
		mem_ra = (state_q == ST_IDLE) ? AW'(cell_index) : sweep_q + AW'(COLUMNS);
		if (wr_s1) begin
			mem_we = 1'b1;
			if (mode_q == SW_INIT) begin
				mem_wd = RESET_CELL;
			end else if (cp_s1) begin
				mem_wd = rd_q;
			end
		end else if (accept && op == OP_PUT && ctl.wr_en) begin
			mem_we = 1'b1;
			mem_wa = ctl.wr_back ? cur_addr - AW'(1) : cur_addr;
			mem_wd = {attr_q, ctl.wr_blank ? BLANK_CHAR : char_code};
		end
	end

	// Screen memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// Sequencer, cursor, attribute and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			mode_q     <= SW_INIT;
			sweep_q    <= '0;
			last_q     <= AW'(CELLS - 1);
			row_q      <= '0;
			col_q      <= '0;
			attr_q     <= RESET_ATTR;
			m_tvalid_q <= 1'b0;
			pos_q      <= '0;
			data_q     <= '0;
			rd_ok_q    <= 1'b0;
			wr_s1      <= 1'b0;
			wa_s1      <= '0;
			cp_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			// drop a word the sink has taken
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			wr_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_PUT: begin
								row_q <= row_d;
								col_q <= col_d;
								if (ctl.scroll) begin
									mode_q  <= SW_SCROLL;
									sweep_q <= '0;
									last_q  <= AW'(WORK_CELLS - 1);
									state_q <= ST_SWEEP;
								end else begin
									m_tvalid_q <= 1'b1;
									pos_q      <= POS_W'(step_addr);
									data_q     <= '0;
								end
							end
							OP_READ: begin
								rd_ok_q <= index_ok;
								state_q <= ST_READ;
							end
							OP_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								mode_q  <= SW_CLEAR;
								sweep_q <= '0;
								last_q  <= AW'(WORK_CELLS - 1);
								state_q <= ST_SWEEP;
							end
							default: begin
								m_tvalid_q <= 1'b1;
								pos_q      <= POS_W'(cur_addr);
								data_q     <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					m_tvalid_q <= 1'b1;
					pos_q      <= POS_W'(cur_addr);
					data_q     <= rd_ok_q ? rd_q : '0;
					state_q    <= ST_IDLE;
				end
				ST_SWEEP: begin
					// issue one cell per cycle; the write follows in the next cycle
					wr_s1 <= 1'b1;
					wa_s1 <= sweep_q;
					cp_s1 <= (mode_q == SW_SCROLL) && (sweep_q < AW'(COPY_CELLS));
					if (sweep_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (mode_q != SW_INIT) begin
						m_tvalid_q <= 1'b1;
						pos_q      <= POS_W'(cur_addr);
						data_q     <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/tmtw_checker.sv =====
// Port-level checks for the text-mode terminal writer core, and their bind.
// Depends on tmtw_pkg; attaches to text_mode_terminal_writer_core.
module tmtw_checker #(
	parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [tmtw_pkg::OP_W-1:0]        s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tmtw_pkg::M_TDATA_W-1:0]   m_tdata
);
	import tmtw_pkg::*;

	localparam int WORK_CELLS = (ROWS - 1) * COLUMNS;
	localparam bit POS_WRAPS  = WORK_CELLS > (1 << POS_W);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Accept only when the result register can take the next word
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input ready while result register is blocked");

	// Keep the cursor above the last row
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> POS_WRAPS || (32'(m_tdata[POS_W-1:0]) < 32'(WORK_CELLS)))
		else $error("cursor position on the last row or beyond");

	// Return a read result by way of the ST_READ state
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_READ |=> ##1 m_tvalid)
		else $error("read result missing");

	// Return an unused-op result on the next cycle
	a_nop_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_NOP |=> m_tvalid)
		else $error("unused-op result missing");

endmodule

bind text_mode_terminal_writer_core tmtw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tmtw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/text_mode_terminal_writer_checker.sv =====
// Port checker for the text-mode terminal writer core: tracks screen, cursor and attribute.
// Watches the config port and both stream ports, predicts each result word and compares.
// Depends on tmtw_pkg.
`timescale 1ns / 100ps

module text_mode_terminal_writer_checker #(
	parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tmtw_pkg::ATTR_W-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tmtw_pkg::S_TDATA_W-1:0] s_tdata,    // char_code [7:0], cell_index [18:8]
	input  logic [tmtw_pkg::OP_W-1:0]      s_tuser,    // operation
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tmtw_pkg::M_TDATA_W-1:0] m_tdata,    // cursor_position [10:0], cell_data [26:11]
	output int                             fail_count,
	output int                             pending
);
	import tmtw_pkg::*;

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int WORK_CELLS = (ROWS - 1) * COLUMNS;
	localparam int PRINT_CAP  = 60;

	typedef struct {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] cdata;
	} cursor_report_t;

	// Shadow copy of the terminal
	logic [CELL_W-1:0] screen [CELLS];
	logic [ATTR_W-1:0] attr;
	int                crow;
	int                ccol;
	cursor_report_t    report_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: MISMATCH %s", $time, what);
		fail_count++;
	endtask

	task automatic blank_span(input int first, input int last_excl);
		for (int i = first; i < last_excl && i < CELLS; i++)
			screen[i] = {attr, BLANK_CHAR};
	endtask

	// Interpret one put: newline, backspace, tab or a stored glyph, then scroll if needed
	task automatic put_glyph(input logic [CHAR_W-1:0] ch);
		if (ch == CH_NEWLINE) begin
			ccol = 0;
			crow++;
		end else if (ch == CH_BACKSPACE) begin
			if (crow != 0 || ccol != 0) begin
				if (ccol == 0) begin
					ccol = COLUMNS - 1;
					crow--;
				end else begin
					ccol--;
				end
				screen[crow * COLUMNS + ccol] = {attr, BLANK_CHAR};
			end
		end else if (ch == CH_TAB) begin
			ccol = ccol + TAB_STOP - (ccol % TAB_STOP);
			if (ccol >= COLUMNS) begin
				ccol = 0;
				crow++;
			end
		end else begin
			screen[crow * COLUMNS + ccol] = {attr, ch};
			ccol++;
			if (ccol >= COLUMNS) begin
				ccol = 0;
				crow++;
			end
		end
		// Scroll up one line once the cursor lands on the last row
		if (crow >= ROWS - 1) begin
			for (int i = 0; i < WORK_CELLS; i++)
				screen[i] = screen[i + COLUMNS];
			blank_span((ROWS - 2) * COLUMNS, WORK_CELLS);
			crow = ROWS - 2;
		end
	endtask

	task automatic apply_terminal_op(input op_t op, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx, output cursor_report_t rpt);
		rpt.cdata = '0;
		case (op)
			OP_PUT: begin
				put_glyph(ch);
			end
			OP_READ: begin
				if (idx < CELLS)
					rpt.cdata = screen[idx];
			end
			OP_CLEAR: begin
				blank_span(0, WORK_CELLS);
				crow = 0;
				ccol = 0;
			end
			default: ;
		endcase
		rpt.pos = POS_W'(crow * COLUMNS + ccol);
	endtask

	// Track config, predict accepted words, compare delivered words
	always @(posedge clk or negedge arst_n) begin
		cursor_report_t rpt;
		cursor_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = RESET_CELL;
			attr = RESET_ATTR;
			crow = 0;
			ccol = 0;
			report_q.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				attr = cfg_wdata;
			if (s_tvalid && s_tready) begin
				apply_terminal_op(op_t'(s_tuser), s_tdata[CHAR_W-1:0],
					s_tdata[CHAR_W +: INDEX_W], rpt);
				report_q.push_back(rpt);
			end
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					want = report_q.pop_front();
					if (m_tdata[POS_W-1:0] !== want.pos)
						report_mismatch($sformatf("cursor_position %0d, want %0d",
							m_tdata[POS_W-1:0], want.pos));
					if (m_tdata[POS_W +: CELL_W] !== want.cdata)
						report_mismatch($sformatf("cell_data %h, want %h",
							m_tdata[POS_W +: CELL_W], want.cdata));
				end
			end
			pending = report_q.size();
		end
	end

endmodule

// ===== tb/tb_text_mode_terminal_writer_core.sv =====
// Testbench top for the text-mode terminal writer core: clock, reset, stimulus and verdict.
// Depends on tmtw_pkg, text_mode_terminal_writer_core and text_mode_terminal_writer_checker.
`timescale 1ns / 100ps

module tb_text_mode_terminal_writer_core;
	import tmtw_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASES       = 5;
	localparam int SETTLE       = (DEF_ROWS - 1) * DEF_COLUMNS + 16;
	localparam int HOLD_CYCLES  = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [ATTR_W-1:0]    cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // char_code [7:0], cell_index [18:8]
	logic [OP_W-1:0]      s_tuser;    // operation
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // cursor_position [10:0], cell_data [26:11]
	int                   fail_count;
	int                   pending;

	int burst_left = 0;
	int words_sent = 0;
	int hold_reqs  = 0;
	int holds_done = 0;

	text_mode_terminal_writer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	text_mode_terminal_writer_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Offer one word, with a random gap before each new burst
	task automatic push_word(input op_t op, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - INDEX_W - CHAR_W){1'b0}}, idx, ch};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch);
		push_word(OP_PUT, ch, INDEX_W'($urandom));
	endtask

	// Drop valid, wait out every result and any scroll still running
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_attr(input logic [ATTR_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random chunk: mostly text with line runs, some reads and odd ops
	task automatic send_random_chunk();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 4) begin
			// long line of printable text, can wrap past the right edge
			n = $urandom_range(60, 100);
			repeat (n) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
		end else if (kind < 7) begin
			// backspace run, can cross row starts
			n = $urandom_range(1, 100);
			repeat (n) put_char(CH_BACKSPACE);
		end else if (kind < 9) begin
			n = $urandom_range(1, 12);
			repeat (n) put_char(CH_TAB);
		end else if (kind < 10) begin
			if ($urandom_range(0, 2) == 0)
				push_word(OP_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
			else
				push_word(OP_NOP, CHAR_W'($urandom), INDEX_W'($urandom));
		end else if (kind < 22) begin
			push_word(OP_READ, CHAR_W'($urandom), INDEX_W'($urandom));
		end else if (kind < 30) begin
			put_char(CH_NEWLINE);
		end else begin
			put_char(CHAR_W'($urandom));
		end
	endtask

	// Receiver: ready pattern by mode, plus requested long hold-offs
	initial begin
		int mode;
		int mode_left;
		mode      = 0;
		mode_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_reqs) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		logic [ATTR_W-1:0] phase_attr;
		int                phase_goal;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_NOP;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset attribute, field extremes, edge cases of the cursor
		push_word(OP_READ, 8'h00, 11'd0);
		push_word(OP_READ, 8'hFF, 11'd1999);
		push_word(OP_READ, 8'h00, 11'd2000);            // past the screen
		push_word(OP_READ, 8'hFF, 11'h7FF);
		put_char(CH_BACKSPACE);                         // at the origin
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(CH_BACKSPACE);
		put_char(CH_TAB);
		put_char(CH_TAB);
		put_char(CH_NEWLINE);
		put_char(CH_BACKSPACE);                         // wraps to end of row 0
		put_char(8'h5A);                                // last column, wraps
		put_char(CH_BACKSPACE);
		put_char(CH_TAB);                               // tab past the edge
		push_word(OP_NOP, 8'hFF, 11'h7FF);
		push_word(OP_READ, 8'h00, 11'd79);
		push_word(OP_READ, 8'h00, 11'd1);
		push_word(OP_CLEAR, 8'h00, 11'd0);
		push_word(OP_READ, 8'h00, 11'd0);
		push_word(OP_READ, 8'h00, 11'd1920);            // last row survives clear
		put_char(8'h7F);

		// Random phases, each under its own attribute
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: phase_attr = 8'h00;
				1: phase_attr = 8'hFF;
				3: phase_attr = RESET_ATTR;
				default: phase_attr = ATTR_W'($urandom);
			endcase
			write_attr(phase_attr);
			if (p == 1 || p == 3)
				hold_reqs++;
			phase_goal = words_sent + RANDOM_ITEMS / PHASES;
			while (words_sent < phase_goal)
				send_random_chunk();
		end

		// Wait out the tail, then give the verdict
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("text_mode_terminal_writer_core test passed");
		else
			$display("text_mode_terminal_writer_core test failed");
		$finish;
	end

	// Timeout
	initial begin
		#40_000_000;
		$display("text_mode_terminal_writer_core test failed");
		$finish;
	end

endmodule
